[hdl/url_form_pair_decoder_macros.svh]
// assertion macros used by the asserting top-level file
`ifndef URL_FORM_PAIR_DECODER_MACROS_SVH
`define URL_FORM_PAIR_DECODER_MACROS_SVH

// same-cycle implication, checked on every clock once reset is released
`define UFPD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ufpd assertion failed");

// next-cycle implication
`define UFPD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ufpd assertion failed");

`endif

[hdl/ufpd_pkg.sv]
`timescale 1ns / 1ps

package ufpd_pkg;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_PLUS  = 8'h2b;
	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_AMP   = 8'h26;
	localparam logic [7:0] CHAR_EQ    = 8'h3d;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam logic [2:0] KIND_KEY    = 3'd0;
	localparam logic [2:0] KIND_VAL    = 3'd1;
	localparam logic [2:0] KIND_DONE   = 3'd2;
	localparam logic [2:0] KIND_NOPAIR = 3'd3;
	localparam logic [2:0] KIND_OVF    = 3'd4;

	// entries of the command queue between front and back
	localparam int CMD_Q_DEPTH = 2;

	typedef struct packed {
		logic is_end;    // '&' or byte 0, else '='
		logic eq_prior;  // an '=' was seen earlier in the segment
		logic ovf;       // buffer overflowed in this segment
	} ufpd_cmd_t;

endpackage

[hdl/ufpd_ram.sv]
`timescale 1ns / 1ps

module ufpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/ufpd_fifo.sv]
`timescale 1ns / 1ps

module ufpd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int NW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    fill_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (fill_q == NW'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + PW'(1));
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + PW'(1));
			end
			if (do_push && !do_pop) begin
				fill_q <= NW'(fill_q + NW'(1));
			end else if (do_pop && !do_push) begin
				fill_q <= NW'(fill_q - NW'(1));
			end
		end
	end

endmodule

[hdl/ufpd_front.sv]
`timescale 1ns / 1ps

module ufpd_front
	import ufpd_pkg::*;
#(
	parameter int BUF_DEPTH = 32,
	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1,
	localparam int CW = $clog2(BUF_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          busy,
	input  logic          q_full,
	output logic          cmd_push,
	output ufpd_cmd_t     cmd,
	output logic [CW-1:0] cmd_cnt,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0]    wr_data
);

	logic [CW-1:0] count_q;
	logic          eq_q;
	logic          ovf_q;
	logic          is_eq;
	logic          is_end;
	logic          is_delim;
	logic          has_room;
	logic          acc;

	assign is_eq    = (in_byte == CHAR_EQ);
	assign is_end   = (in_byte == CHAR_AMP) || (in_byte == CHAR_NUL);
	assign is_delim = is_eq || is_end;
	assign has_room = (count_q < CW'(BUF_DEPTH));

	// while the back is busy or commands are queued only delimiters get through
	assign in_ready = busy ? (is_delim && !q_full) : 1'b1;
	assign acc      = in_valid && in_ready;

	assign cmd_push     = acc && is_delim;
	assign cmd.is_end   = is_end;
	assign cmd.eq_prior = eq_q;
	assign cmd.ovf      = ovf_q;
	assign cmd_cnt      = count_q;

	assign wr_en   = acc && !is_delim && has_room;
	assign wr_addr = count_q[AW-1:0];
	assign wr_data = in_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			eq_q    <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (acc) begin
			if (is_eq) begin
				count_q <= '0;
				eq_q    <= 1'b1;
			end else if (is_end) begin
				count_q <= '0;
				eq_q    <= 1'b0;
				ovf_q   <= 1'b0;
			end else if (has_room) begin
				count_q <= CW'(count_q + CW'(1));
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule

[hdl/ufpd_back.sv]
`timescale 1ns / 1ps

module ufpd_back
	import ufpd_pkg::*;
#(
	parameter int BUF_DEPTH = 32,
	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1,
	localparam int CW = $clog2(BUF_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  ufpd_cmd_t     q_cmd,
	input  logic [CW-1:0] q_cnt,
	output logic          q_pop,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  logic [7:0]    rd_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic [2:0]    kind,
	output logic          last_of_run,
	output logic          idle
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EQCH  = 3'd1;
	localparam logic [2:0] ST_FINK  = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_FINV  = 3'd4;
	localparam logic [2:0] ST_MARK  = 3'd5;
	localparam logic [2:0] ST_FLUSH = 3'd6;

	function automatic logic [4:0] hexval(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic logic [7:0] decode_pair(input logic [7:0] c1, input logic [7:0] c2);
		logic [4:0] h1;
		logic [4:0] h2;
		logic [7:0] r;
		h1 = hexval(c1);
		h2 = hexval(c2);
		if (!h1[4]) begin
			r = c2;
		end else if (!h2[4]) begin
			r = {4'd0, h1[3:0]};
		end else begin
			r = {h1[3:0], h2[3:0]};
		end
		return r;
	endfunction

	logic [2:0]    state_q;
	ufpd_cmd_t     cmd_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rd_idx_q;
	logic          rd_v_s1;
	logic [1:0]    phase_q;
	logic [7:0]    first_q;
	logic [2:0]    kind_q;
	logic          hold_v_q;
	logic [7:0]    hold_byte_q;
	logic [2:0]    hold_kind_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic [2:0]    out_kind_q;
	logic          out_last_q;

	logic          advance;
	logic          issue;
	logic [7:0]    dec_c;
	logic          f_v;
	logic [7:0]    f_b;
	logic [1:0]    f_phase;
	logic [7:0]    f_first;
	logic          fin_v;
	logic [7:0]    fin_b;
	logic [7:0]    pair_b;
	logic          cand_v;
	logic [7:0]    cand_b;
	logic [2:0]    cand_kind;
	logic          push_v;

	assign advance = !out_valid_q || out_ready;
	assign q_pop   = (state_q == ST_IDLE) && q_valid;
	assign idle    = (state_q == ST_IDLE);
	assign issue   = advance && (state_q == ST_READ) && (rd_idx_q < cnt_q);
	assign rd_en   = issue;
	assign rd_addr = rd_idx_q[AW-1:0];
	assign dec_c   = (state_q == ST_EQCH) ? CHAR_EQ : rd_data;

	// one character into the escape decoder
	always_comb begin
		f_v     = 1'b0;
		f_b     = dec_c;
		f_phase = phase_q;
		f_first = first_q;
		pair_b  = decode_pair(first_q, dec_c);
		case (phase_q)
			2'd1: begin
				f_first = dec_c;
				f_phase = 2'd2;
			end
			2'd2: begin
				f_b     = pair_b;
				f_v     = (pair_b != 8'd0);
				f_phase = 2'd0;
				f_first = 8'd0;
			end
			default: begin
				if (dec_c == CHAR_PLUS) begin
					f_b = CHAR_SPACE;
					f_v = 1'b1;
				end else if (dec_c == CHAR_PCT) begin
					f_phase = 2'd1;
				end else begin
					f_v = (dec_c != 8'd0);
				end
			end
		endcase
	end

	// close an escape left open at the end of a key or value
	always_comb begin
		fin_v = 1'b0;
		fin_b = decode_pair(first_q, 8'd0);
		case (phase_q)
			2'd1: begin
				fin_v = 1'b1;
				fin_b = CHAR_PCT;
			end
			2'd2: begin
				fin_v = (fin_b != 8'd0);
			end
			default: begin
				fin_v = 1'b0;
			end
		endcase
	end

	always_comb begin
		cand_v    = 1'b0;
		cand_b    = f_b;
		cand_kind = kind_q;
		case (state_q)
			ST_EQCH: begin
				cand_v    = f_v;
				cand_kind = KIND_KEY;
			end
			ST_FINK: begin
				cand_v    = fin_v;
				cand_b    = fin_b;
				cand_kind = KIND_KEY;
			end
			ST_READ: begin
				cand_v = rd_v_s1 && f_v;
			end
			ST_FINV: begin
				cand_v    = fin_v;
				cand_b    = fin_b;
				cand_kind = KIND_VAL;
			end
			ST_MARK: begin
				cand_v = 1'b1;
				cand_b = 8'd0;
				if (!cmd_q.eq_prior) begin
					cand_kind = KIND_NOPAIR;
				end else if (cmd_q.ovf) begin
					cand_kind = KIND_OVF;
				end else begin
					cand_kind = KIND_DONE;
				end
			end
			default: begin
				cand_v = 1'b0;
			end
		endcase
	end

	// the held word goes out once a later one or the end of the run shows whether it is last
	assign push_v = advance && hold_v_q && (cand_v || (state_q == ST_FLUSH));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
			cnt_q <= q_cnt;
		end
		if (advance && cand_v) begin
			hold_byte_q <= cand_b;
			hold_kind_q <= cand_kind;
		end
		if (push_v) begin
			out_byte_q <= hold_byte_q;
			out_kind_q <= hold_kind_q;
			out_last_q <= (state_q == ST_FLUSH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			rd_v_s1     <= 1'b0;
			phase_q     <= 2'd0;
			first_q     <= 8'd0;
			kind_q      <= KIND_KEY;
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_v) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance && cand_v) begin
				hold_v_q <= 1'b1;
			end else if (advance && state_q == ST_FLUSH) begin
				hold_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						rd_idx_q <= '0;
						rd_v_s1  <= 1'b0;
						kind_q   <= KIND_KEY;
						if (!q_cmd.is_end) begin
							state_q <= q_cmd.eq_prior ? ST_EQCH : ST_READ;
						end else begin
							state_q <= q_cmd.eq_prior ? ST_FINK : ST_MARK;
						end
					end
				end
				ST_EQCH: begin
					if (advance) begin
						phase_q <= f_phase;
						first_q <= f_first;
						state_q <= ST_READ;
					end
				end
				ST_FINK: begin
					if (advance) begin
						phase_q <= 2'd0;
						first_q <= 8'd0;
						kind_q  <= KIND_VAL;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (advance) begin
						rd_v_s1 <= issue;
						if (issue) begin
							rd_idx_q <= CW'(rd_idx_q + CW'(1));
						end
						if (rd_v_s1) begin
							phase_q <= f_phase;
							first_q <= f_first;
						end
						if (!issue && !rd_v_s1) begin
							state_q <= cmd_q.is_end ? ST_FINV : ST_FLUSH;
						end
					end
				end
				ST_FINV: begin
					if (advance) begin
						phase_q <= 2'd0;
						first_q <= 8'd0;
						state_q <= ST_MARK;
					end
				end
				ST_MARK: begin
					if (advance) begin
						phase_q <= 2'd0;
						first_q <= 8'd0;
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (advance) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign kind        = out_kind_q;
	assign last_of_run = out_last_q;

endmodule

[hdl/url_form_pair_decoder.sv]
`timescale 1ns / 1ps
// url_form_pair_decoder: splits query-string text into un-escaped key and value words
// input channel (in_valid/in_ready/in_byte): one raw text byte per word
// output channel (out_valid/out_ready/out_byte/kind/last_of_run): decoded words and
//   segment markers; last_of_run flags the final word caused by one input byte
// plain bytes (one per cycle while not busy) fill the segment buffer, give no output
// '=' and '&' (or byte 0) go into a two-entry command queue; the back end then
//   reads the buffer through the registered memory port at one byte per cycle while
//   the receiver does not stall, and sends at most one word per cycle
// a delimiter keeps the back end busy through the queue pop, the buffer reads, the
//   escape close, the marker and the held last word; its last word is offered as
//   the back end goes idle
// while commands are queued or the back end is busy, only delimiters are taken, and
//   only while the command queue has room; plain bytes wait until both are done
// a stalled receiver freezes the back end in place; the front end keeps taking
//   words until the rules above stop it
// reset clears all control state at once; buffer contents stay undefined and are
//   never read before they are written, so there is no clearing pass

`include "url_form_pair_decoder_macros.svh"

module url_form_pair_decoder
	import ufpd_pkg::*;
#(
	parameter int BUF_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [2:0] kind,
	output logic       last_of_run
);

	localparam int AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int CW    = $clog2(BUF_DEPTH + 1);
	localparam int CMD_W = $bits(ufpd_cmd_t) + CW;

	logic             busy;
	logic             q_full;
	logic             q_empty;
	logic             q_push;
	logic             q_pop;
	ufpd_cmd_t        f_cmd;
	logic [CW-1:0]    f_cnt;
	logic [CMD_W-1:0] q_din;
	logic [CMD_W-1:0] q_dout;
	ufpd_cmd_t        q_cmd;
	logic [CW-1:0]    q_cnt;
	logic             back_idle;
	logic             ram_wr_en;
	logic [AW-1:0]    ram_wr_addr;
	logic [7:0]       ram_wr_data;
	logic             ram_rd_en;
	logic [AW-1:0]    ram_rd_addr;
	logic [7:0]       ram_rd_data;

	assign busy  = !q_empty || !back_idle;
	assign q_din = {f_cmd, f_cnt};
	assign q_cmd = ufpd_cmd_t'(q_dout[CMD_W-1:CW]);
	assign q_cnt = q_dout[CW-1:0];

	ufpd_front #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte (in_byte),
		.busy    (busy),
		.q_full  (q_full),
		.cmd_push(q_push),
		.cmd     (f_cmd),
		.cmd_cnt (f_cnt),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data)
	);

	ufpd_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(CMD_Q_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	ufpd_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_buf (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	ufpd_back #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (!q_empty),
		.q_cmd      (q_cmd),
		.q_cnt      (q_cnt),
		.q_pop      (q_pop),
		.rd_en      (ram_rd_en),
		.rd_addr    (ram_rd_addr),
		.rd_data    (ram_rd_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.kind       (kind),
		.last_of_run(last_of_run),
		.idle       (back_idle)
	);

	// markers close a run and carry no byte
	`UFPD_ASSERT_IMP(a_marker_last, out_valid && (kind == KIND_DONE || kind == KIND_NOPAIR || kind == KIND_OVF), last_of_run && out_byte == 8'd0)
	// the buffer is never written while queued or running commands still read it
	`UFPD_ASSERT_IMP(a_no_write_busy, ram_wr_en, q_empty && back_idle)
	// a popped command always starts the back end
	`UFPD_ASSERT_NXT(a_pop_starts, q_pop, !back_idle)

endmodule

[tb/tb_url_form_pair_decoder.sv]
`timescale 1ns / 1ps

module tb_url_form_pair_decoder;
	import ufpd_pkg::*;

	localparam int DEPTH = 32;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] kind;
		logic       last;
	} dec_word_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic [2:0] kind;
	logic       last_of_run;

	url_form_pair_decoder #(.BUF_DEPTH(DEPTH)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.kind       (kind),
		.last_of_run(last_of_run)
	);

	// decoded words still owed by the block, oldest first
	dec_word_t want_words[$];
	dec_word_t step_words[$];
	dec_word_t got_word;
	int fail_count = 0;
	int bytes_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	// shadow of the segment state
	logic [7:0] seg_buf[DEPTH];
	int         seg_count = 0;
	logic       seg_eq_seen = 0;
	logic [1:0] key_esc_phase = 0;
	logic [7:0] key_esc_c1 = 0;
	logic       seg_overflow = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_url_form_pair_decoder failed");
		$finish;
	end

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
		if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
		return -1;
	endfunction

	function automatic logic [7:0] unescape_pair(input logic [7:0] c1, input logic [7:0] c2);
		int h1;
		int h2;
		h1 = hex_nibble(c1);
		h2 = hex_nibble(c2);
		if (h1 < 0) return c2;
		if (h2 < 0) return h1[7:0];
		return 8'(h1 * 16 + h2);
	endfunction

	function automatic void add_word(input logic [7:0] b, input logic [2:0] k, input bit drop_zero);
		dec_word_t w;
		if (drop_zero && b == 8'h00) return;
		w.data = b;
		w.kind = k;
		w.last = 1'b0;
		step_words.push_back(w);
	endfunction

	function automatic void unescape_feed(inout logic [1:0] ph, inout logic [7:0] c1,
		input logic [7:0] c, input logic [2:0] k);
		if (ph == 2'd1) begin
			c1 = c;
			ph = 2'd2;
		end else if (ph == 2'd2) begin
			add_word(unescape_pair(c1, c), k, 1'b1);
			ph = 2'd0;
			c1 = 8'h00;
		end else if (c == CHAR_PLUS) begin
			add_word(CHAR_SPACE, k, 1'b0);
		end else if (c == CHAR_PCT) begin
			ph = 2'd1;
		end else begin
			add_word(c, k, 1'b1);
		end
	endfunction

	function automatic void unescape_flush(inout logic [1:0] ph, inout logic [7:0] c1,
		input logic [2:0] k);
		if (ph == 2'd1)
			add_word(CHAR_PCT, k, 1'b0);
		else if (ph == 2'd2)
			add_word(unescape_pair(c1, 8'h00), k, 1'b1);
		ph = 2'd0;
		c1 = 8'h00;
	endfunction

	// works out the words one raw byte causes and queues them
	function automatic void predict_decode(input logic [7:0] b);
		logic [1:0] val_phase;
		logic [7:0] val_c1;
		dec_word_t  w;
		val_phase = 2'd0;
		val_c1 = 8'h00;
		step_words.delete();
		if (b == CHAR_EQ) begin
			// an earlier '=' turns out to be part of the key
			if (seg_eq_seen)
				unescape_feed(key_esc_phase, key_esc_c1, CHAR_EQ, KIND_KEY);
			for (int i = 0; i < seg_count; i++)
				unescape_feed(key_esc_phase, key_esc_c1, seg_buf[i], KIND_KEY);
			seg_count = 0;
			seg_eq_seen = 1'b1;
		end else if (b == CHAR_AMP || b == CHAR_NUL) begin
			if (seg_eq_seen) begin
				unescape_flush(key_esc_phase, key_esc_c1, KIND_KEY);
				for (int i = 0; i < seg_count; i++)
					unescape_feed(val_phase, val_c1, seg_buf[i], KIND_VAL);
				unescape_flush(val_phase, val_c1, KIND_VAL);
				add_word(8'h00, seg_overflow ? KIND_OVF : KIND_DONE, 1'b0);
			end else begin
				add_word(8'h00, KIND_NOPAIR, 1'b0);
			end
			seg_count = 0;
			seg_eq_seen = 1'b0;
			key_esc_phase = 2'd0;
			key_esc_c1 = 8'h00;
			seg_overflow = 1'b0;
		end else if (seg_count < DEPTH) begin
			seg_buf[seg_count] = b;
			seg_count++;
		end else begin
			seg_overflow = 1'b1;
		end
		if (step_words.size() > 0)
			step_words[step_words.size() - 1].last = 1'b1;
		while (step_words.size() > 0) begin
			w = step_words.pop_front();
			want_words.push_back(w);
		end
	endfunction

	// valid stays high after acceptance unless the next call idles first
	task automatic send_word(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_decode(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i]);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (want_words.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] rand_text_char();
		int r;
		logic [7:0] c;
		r = $urandom_range(99);
		if (r < 35)
			c = 8'(8'h61 + $urandom_range(0, 25));
		else if (r < 50)
			c = 8'(8'h30 + $urandom_range(0, 9));
		else if (r < 58)
			c = 8'(8'h41 + $urandom_range(0, 5));
		else if (r < 66)
			c = CHAR_PLUS;
		else if (r < 78)
			c = CHAR_PCT;
		else if (r < 83)
			c = CHAR_EQ;
		else begin
			c = 8'($urandom_range(1, 255));
			if (c == CHAR_AMP)
				c = 8'hff;
		end
		return c;
	endfunction

	task automatic send_random_segment();
		int r;
		int key_len;
		int val_len;
		r = $urandom_range(99);
		if (r < 6) begin
			key_len = $urandom_range(0, 4);
			val_len = $urandom_range(30, 36);
		end else if (r < 9) begin
			key_len = $urandom_range(30, 36);
			val_len = $urandom_range(0, 3);
		end else begin
			key_len = $urandom_range(0, 8);
			val_len = $urandom_range(0, 8);
		end
		repeat (key_len) send_word(rand_text_char());
		if ($urandom_range(99) < 85) begin
			send_word(CHAR_EQ);
			repeat (val_len) send_word(rand_text_char());
		end
		// now and then leave the segment open so it runs into the next one
		if ($urandom_range(99) < 5)
			return;
		send_word($urandom_range(99) < 85 ? CHAR_AMP : CHAR_NUL);
	endtask

	task automatic test_directed();
		// plus, escape carried over a key '=', decoded zero dropped
		send_text("a+%4=1=%00&");
		// lone trailing percent in key, non-hex c1 at value end
		send_text("k%=%g");
		send_word(CHAR_NUL);
		// non-hex c1 passes c2, hex c1 with byte extremes after it
		send_text("%zq=%f");
		send_word(8'hff);
		send_word(8'h80);
		send_word(8'h01);
		send_text("=%a&");
		// empty segments and one without '='
		send_text("&");
		send_word(CHAR_NUL);
		send_text("%a&");
		wait_drained();
	endtask

	task automatic test_buffer_full();
		send_word(CHAR_EQ);
		repeat (DEPTH + 3) send_word(8'(8'h61 + $urandom_range(0, 25)));
		send_word(CHAR_AMP);
		repeat (DEPTH + 6) send_word(8'(8'h30 + $urandom_range(0, 9)));
		send_word(CHAR_AMP);
		repeat (DEPTH + 1) send_word(8'(8'h41 + $urandom_range(0, 5)));
		send_word(CHAR_EQ);
		send_word(CHAR_NUL);
		// exactly full is still a normal pair
		repeat (DEPTH) send_word(8'h62);
		send_word(CHAR_EQ);
		repeat (DEPTH) send_word(CHAR_PLUS);
		send_word(CHAR_AMP);
		wait_drained();
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_bytes);
		int stop_at;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at)
			send_random_segment();
		send_word(CHAR_AMP);
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 300;
		repeat (4) send_text("ab=c%41&");
		send_text("x=y");
		send_word(CHAR_NUL);
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (want_words.size() == 0) begin
				$error("unexpected word: out_byte %0h kind %0d last_of_run %0b",
					out_byte, kind, last_of_run);
				fail_count++;
			end else begin
				got_word = want_words.pop_front();
				if (out_byte !== got_word.data) begin
					$error("out_byte: expected %0h, got %0h", got_word.data, out_byte);
					fail_count++;
				end
				if (kind !== got_word.kind) begin
					$error("kind: expected %0d, got %0d", got_word.kind, kind);
					fail_count++;
				end
				if (last_of_run !== got_word.last) begin
					$error("last_of_run: expected %0b, got %0b", got_word.last, last_of_run);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		out_ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_buffer_full();
		test_random_phase(0, 0, 15);
		test_random_phase(58, 0, 15);
		test_random_phase(0, 58, 15);
		test_random_phase(16, 16, 15);
		test_backpressure();

		// stray words would show up in this closing wait with the receiver always ready
		recv_stall_pct = 0;
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("tb_url_form_pair_decoder passed");
		else
			$display("tb_url_form_pair_decoder failed");
		$finish;
	end

endmodule

[sim.f]
+incdir+hdl
hdl/ufpd_pkg.sv
hdl/ufpd_ram.sv
hdl/ufpd_fifo.sv
hdl/ufpd_front.sv
hdl/ufpd_back.sv
hdl/url_form_pair_decoder.sv
tb/tb_url_form_pair_decoder.sv
